// File: src/bwbe_pkg.sv
package bwbe_pkg;

    // Time stamps are 40-bit wrapping sample counts, scaled by the fraction bits.
    localparam int TIME_W  = 40;
    localparam int SPAN_W  = 32;
    localparam int BEAT_W  = 16;
    localparam int Q_SHIFT = 16;
    localparam int COEF_W  = 17;

    // Threshold coefficients in Q0.16, kept one bit wider so they stay positive when signed.
    localparam logic signed [COEF_W-1:0] C_TENTH  = 17'sd6554;
    localparam logic signed [COEF_W-1:0] C_HALF   = 17'sd32768;
    localparam logic signed [COEF_W-1:0] C_INV_E  = 17'sd24109;

    // Difference of two time stamps, taken modulo 2^40 and saturated to 32 bits.
    function automatic logic signed [SPAN_W-1:0] span(input logic [TIME_W-1:0] t_end,
                                                      input logic [TIME_W-1:0] t_start);
        logic [TIME_W-1:0] d;
        d = t_end - t_start;
        if (!d[TIME_W-1] && (|d[TIME_W-2:SPAN_W-1])) begin
            span = {1'b0, {(SPAN_W-1){1'b1}}};
        end
        else if (d[TIME_W-1] && !(&d[TIME_W-2:SPAN_W-1])) begin
            span = {1'b1, {(SPAN_W-1){1'b0}}};
        end
        else begin
            span = d[SPAN_W-1:0];
        end
    endfunction

endpackage

// File: src/beat_waveform_biomarker_extractor.sv
// Channel      | Direction | Handshake                    | Payload
// -------------+-----------+------------------------------+-------------------------------
// sample       | in        | sample_valid / sample_stall  | volt, ca_cyto, ca_sr, na_cyto,
//              |           |                              | end_of_beat
// result       | out       | result_valid / result_stall  | beat_number ... time_to_peak
// config (APB) | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A sample is captured, its extremes are updated and four crossings are checked; each of up to four
// crossings that need an interpolated time then waits on the divider. On a beat boundary, the
// result is loaded and the four new threshold levels follow, each by a multiply and an add step.
// All crossings share the one restoring divider, which produces one bit a cycle.
// sample_stall is high for the whole time a sample is being worked on.
// A boundary result waits in its output register. The next boundary holds only if that
// register is still full. rst_n clears all state at once, and there is no clearing pass.
module beat_waveform_biomarker_extractor #(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int TIME_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        volt,
    input  logic signed [SAMPLE_WIDTH-1:0]        ca_cyto,
    input  logic signed [SAMPLE_WIDTH-1:0]        ca_sr,
    input  logic signed [SAMPLE_WIDTH-1:0]        na_cyto,
    input  logic                                  end_of_beat,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [bwbe_pkg::BEAT_W-1:0]           beat_number,
    output logic signed [bwbe_pkg::SPAN_W-1:0]    apd,
    output logic signed [SAMPLE_WIDTH-1:0]        ca_peak,
    output logic signed [SAMPLE_WIDTH-1:0]        ca_at_boundary,
    output logic signed [SAMPLE_WIDTH-1:0]        sr_peak,
    output logic signed [SAMPLE_WIDTH-1:0]        sr_trough,
    output logic signed [SAMPLE_WIDTH-1:0]        na_peak,
    output logic signed [SAMPLE_WIDTH-1:0]        na_trough,
    output logic signed [bwbe_pkg::SPAN_W-1:0]    decay_half,
    output logic signed [bwbe_pkg::SPAN_W-1:0]    decay_tau,
    output logic signed [bwbe_pkg::SPAN_W-1:0]    decay_ninety,
    output logic signed [bwbe_pkg::SPAN_W-1:0]    time_to_peak
);

    import bwbe_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SW + 1;
    localparam int QW = TIME_FRAC_BITS + 1;
    localparam int PW = DW + COEF_W;

    localparam longint SMAX      = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SMIN      = -SMAX - 1;
    localparam longint LARGE_RAW = longint'(100000) * 65536;
    localparam longint VHI_RAW   = longint'(1000) * 65536;
    localparam longint VLO_RAW   = -VHI_RAW;
    localparam longint LARGE     = (LARGE_RAW > SMAX) ? SMAX : LARGE_RAW;
    localparam longint VHI       = (VHI_RAW > SMAX) ? SMAX : VHI_RAW;
    localparam longint VLO       = (VLO_RAW < SMIN) ? SMIN : VLO_RAW;

    localparam logic signed [SW-1:0] LARGE_V = SW'(LARGE);
    localparam logic signed [SW-1:0] VHI_V   = SW'(VHI);
    localparam logic signed [SW-1:0] VLO_V   = SW'(VLO);
    localparam logic signed [PW:0]   SMAX_S  = (PW + 1)'(SMAX);
    localparam logic signed [PW:0]   SMIN_S  = (PW + 1)'(SMIN);
    localparam logic signed [PW-1:0] ROUND_C = PW'(1) <<< (Q_SHIFT - 1);
    localparam logic [BEAT_W-1:0]    BEAT_MAX = '1;

    localparam logic [2:0] ADDR_WARMUP = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXTREME, ST_CHECK, ST_DIVWAIT, ST_BOUND, ST_LMUL, ST_LADD, ST_FIN
    } state_t;

    state_t state_reg;

    logic [BEAT_W-1:0] warmup_reg;

    // Captured sample.
    logic signed [SW-1:0] v_reg;
    logic signed [SW-1:0] ca_reg;
    logic signed [SW-1:0] sr_reg;
    logic signed [SW-1:0] na_reg;
    logic                 eob_reg;

    logic [TIME_W-1:0] clk_cnt_reg;
    logic [BEAT_W-1:0] beat_count_reg;

    logic signed [SW-1:0] ca_high_reg;
    logic signed [SW-1:0] ca_low_reg;
    logic [TIME_W-1:0]    ca_high_time_reg;
    logic [TIME_W-1:0]    ca_low_time_reg;
    logic signed [SW-1:0] sr_max_reg;
    logic signed [SW-1:0] sr_min_reg;
    logic signed [SW-1:0] na_max_reg;
    logic signed [SW-1:0] na_min_reg;
    logic signed [SW-1:0] v_max_reg;
    logic signed [SW-1:0] v_min_reg;
    logic signed [SW-1:0] prev_v_reg;
    logic signed [SW-1:0] prev_ca_reg;

    // Thresholds: volt, half, ninety, tau. Two banks alternate by beat parity.
    logic signed [SW-1:0] act_reg  [4];
    logic signed [SW-1:0] bank_reg [2][4];
    logic signed [SW-1:0] nv_reg   [4];

    // Interval flags and start/end time pairs: APD, half, ninety, tau.
    logic [3:0]        flags_reg;
    logic [TIME_W-1:0] times_reg [8];

    logic [1:0]           idx_reg;
    logic [2:0]           slot_reg;
    logic [1:0]           lidx_reg;
    logic signed [PW-1:0] prod_reg;

    logic                 result_valid_reg;
    logic [BEAT_W-1:0]    beat_number_reg;
    logic signed [SPAN_W-1:0] apd_reg;
    logic signed [SW-1:0] ca_peak_reg;
    logic signed [SW-1:0] ca_at_boundary_reg;
    logic signed [SW-1:0] sr_peak_reg;
    logic signed [SW-1:0] sr_trough_reg;
    logic signed [SW-1:0] na_peak_reg;
    logic signed [SW-1:0] na_trough_reg;
    logic signed [SPAN_W-1:0] decay_half_reg;
    logic signed [SPAN_W-1:0] decay_tau_reg;
    logic signed [SPAN_W-1:0] decay_ninety_reg;
    logic signed [SPAN_W-1:0] time_to_peak_reg;

    // Crossing check for the threshold selected by idx_reg.
    logic signed [SW-1:0] chk_cur;
    logic signed [SW-1:0] chk_old;
    logic signed [SW-1:0] chk_thr;
    logic                 chk_flag;
    logic                 chk_after;
    logic                 live;
    logic                 go_start;
    logic                 go_end;
    logic                 need_interp;
    logic signed [DW-1:0] ip_num;
    logic signed [DW-1:0] ip_den;
    logic [DW-1:0]        ip_a;
    logic [DW-1:0]        ip_b;
    logic                 ip_zero;
    logic [TIME_W-1:0]    scaled_clk;
    logic [TIME_W-1:0]    scaled_high;
    logic [TIME_W-1:0]    scaled_low;
    state_t               after_check;

    logic          div_start;
    logic          div_done;
    logic [QW-1:0] div_q;

    // Threshold level unit: one multiply, then one add and saturate.
    logic signed [SW-1:0]     lv_base;
    logic signed [SW-1:0]     lv_peak;
    logic signed [COEF_W-1:0] lv_coef;
    logic signed [DW-1:0]     lv_diff;
    logic signed [PW-1:0]     lv_shift;
    logic signed [PW:0]       lv_sum;
    logic signed [SW-1:0]     lv_sat;

    logic emit;
    logic out_free;
    logic res_load;
    logic cfg_write;

    assign live        = beat_count_reg != '0;
    assign chk_cur     = (idx_reg == 2'd0) ? v_reg : ca_reg;
    assign chk_old     = (idx_reg == 2'd0) ? prev_v_reg : prev_ca_reg;
    assign chk_thr     = act_reg[idx_reg];
    assign chk_flag    = flags_reg[idx_reg];
    assign chk_after   = (idx_reg == 2'd0) || (clk_cnt_reg > ca_high_time_reg);
    assign go_start    = !chk_flag && chk_after && (chk_cur > chk_thr) && live;
    assign go_end      = chk_flag && chk_after && (chk_cur < chk_thr) && live;
    assign need_interp = go_end || (go_start && (idx_reg == 2'd0));

    assign ip_num  = DW'(chk_cur) - DW'(chk_thr);
    assign ip_den  = DW'(chk_cur) - DW'(chk_old);
    assign ip_a    = ip_num[DW-1] ? DW'(-ip_num) : DW'(ip_num);
    assign ip_b    = ip_den[DW-1] ? DW'(-ip_den) : DW'(ip_den);
    assign ip_zero = (ip_num == '0) || (ip_den == '0) || (ip_num[DW-1] != ip_den[DW-1]);

    assign scaled_clk  = clk_cnt_reg << TIME_FRAC_BITS;
    assign scaled_high = ca_high_time_reg << TIME_FRAC_BITS;
    assign scaled_low  = ca_low_time_reg << TIME_FRAC_BITS;

    assign after_check = (idx_reg != 2'd3) ? ST_CHECK : (eob_reg ? ST_BOUND : ST_FIN);
    assign div_start   = (state_reg == ST_CHECK) && need_interp && !ip_zero;

    bwbe_div #(
        .OP_W (DW),
        .FRAC (TIME_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ip_a),
        .den   (ip_b),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb begin
        lv_base = (lidx_reg == 2'd0) ? v_min_reg : ca_reg;
        lv_peak = (lidx_reg == 2'd0) ? v_max_reg : ca_high_reg;
        case (lidx_reg)
            2'd1:    lv_coef = C_HALF;
            2'd3:    lv_coef = C_INV_E;
            default: lv_coef = C_TENTH;
        endcase
        lv_diff  = DW'(lv_peak) - DW'(lv_base);
        // An arithmetic shift floors, which matches rounding ties upward in both signs.
        lv_shift = prod_reg >>> Q_SHIFT;
        lv_sum   = (PW + 1)'(lv_base) + (PW + 1)'(lv_shift);
        if (lv_sum > SMAX_S) begin
            lv_sat = SW'(SMAX);
        end
        else if (lv_sum < SMIN_S) begin
            lv_sat = SW'(SMIN);
        end
        else begin
            lv_sat = lv_sum[SW-1:0];
        end
    end

    assign emit      = beat_count_reg > warmup_reg;
    assign out_free  = !result_valid_reg || !result_stall;
    // A result is loaded on the boundary step; this may coincide with the old one leaving.
    assign res_load  = (state_reg == ST_BOUND) && emit && out_free;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            warmup_reg <= BEAT_W'(20);
        end
        else if (cfg_write && (paddr[2] == ADDR_WARMUP[2])) begin
            warmup_reg <= pwdata[BEAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg          <= ST_IDLE;
            v_reg              <= '0;
            ca_reg             <= '0;
            sr_reg             <= '0;
            na_reg             <= '0;
            eob_reg            <= 1'b0;
            clk_cnt_reg        <= '0;
            beat_count_reg     <= '0;
            ca_high_reg        <= '0;
            ca_low_reg         <= LARGE_V;
            ca_high_time_reg   <= '0;
            ca_low_time_reg    <= '0;
            sr_max_reg         <= '0;
            sr_min_reg         <= LARGE_V;
            na_max_reg         <= '0;
            na_min_reg         <= LARGE_V;
            v_max_reg          <= VLO_V;
            v_min_reg          <= VHI_V;
            prev_v_reg         <= '0;
            prev_ca_reg        <= '0;
            for (int i = 0; i < 4; i++) begin
                act_reg[i]     <= '0;
                bank_reg[0][i] <= '0;
                bank_reg[1][i] <= '0;
                nv_reg[i]      <= '0;
            end
            flags_reg          <= '0;
            for (int i = 0; i < 8; i++) begin
                times_reg[i]   <= '0;
            end
            idx_reg            <= '0;
            slot_reg           <= '0;
            lidx_reg           <= '0;
            prod_reg           <= '0;
            result_valid_reg   <= 1'b0;
            beat_number_reg    <= '0;
            apd_reg            <= '0;
            ca_peak_reg        <= '0;
            ca_at_boundary_reg <= '0;
            sr_peak_reg        <= '0;
            sr_trough_reg      <= '0;
            na_peak_reg        <= '0;
            na_trough_reg      <= '0;
            decay_half_reg     <= '0;
            decay_tau_reg      <= '0;
            decay_ninety_reg   <= '0;
            time_to_peak_reg   <= '0;
        end
        else begin
            if (res_load) begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall) begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (sample_valid) begin
                        v_reg     <= volt;
                        ca_reg    <= ca_cyto;
                        sr_reg    <= ca_sr;
                        na_reg    <= na_cyto;
                        eob_reg   <= end_of_beat;
                        state_reg <= ST_EXTREME;
                    end
                end

                ST_EXTREME: begin
                    // A new calcium maximum restarts the half and ninety decay intervals.
                    if (ca_reg > ca_high_reg) begin
                        ca_high_reg      <= ca_reg;
                        ca_high_time_reg <= clk_cnt_reg;
                        flags_reg[1]     <= 1'b0;
                        flags_reg[2]     <= 1'b0;
                    end
                    if (ca_reg < ca_low_reg) begin
                        ca_low_reg      <= ca_reg;
                        ca_low_time_reg <= clk_cnt_reg;
                    end
                    if (sr_reg > sr_max_reg) sr_max_reg <= sr_reg;
                    if (sr_reg < sr_min_reg) sr_min_reg <= sr_reg;
                    if (na_reg > na_max_reg) na_max_reg <= na_reg;
                    if (na_reg < na_min_reg) na_min_reg <= na_reg;
                    if (v_reg > v_max_reg)   v_max_reg  <= v_reg;
                    if (v_reg < v_min_reg)   v_min_reg  <= v_reg;
                    idx_reg   <= '0;
                    state_reg <= ST_CHECK;
                end

                ST_CHECK: begin
                    slot_reg <= {idx_reg, go_end};
                    if (go_start) begin
                        flags_reg[idx_reg] <= 1'b1;
                        if (idx_reg != 2'd0) begin
                            // Calcium decay intervals start at the peak time.
                            times_reg[{idx_reg, 1'b0}] <= scaled_high;
                        end
                    end
                    if (go_end) begin
                        flags_reg[idx_reg] <= 1'b0;
                    end
                    if (need_interp && !ip_zero) begin
                        state_reg <= ST_DIVWAIT;
                    end
                    else begin
                        if (need_interp) begin
                            times_reg[{idx_reg, go_end}] <= scaled_clk;
                        end
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= after_check;
                    end
                end

                ST_DIVWAIT: begin
                    if (div_done) begin
                        // The crossing lay this fraction of a sample before the current one.
                        times_reg[slot_reg] <= scaled_clk - TIME_W'(div_q);
                        idx_reg             <= idx_reg + 2'd1;
                        state_reg           <= after_check;
                    end
                end

                ST_BOUND: begin
                    if (!emit || out_free) begin
                        if (emit) begin
                            beat_number_reg    <= beat_count_reg;
                            apd_reg            <= span(times_reg[1], times_reg[0]);
                            ca_peak_reg        <= ca_high_reg;
                            ca_at_boundary_reg <= ca_reg;
                            sr_peak_reg        <= sr_max_reg;
                            sr_trough_reg      <= sr_min_reg;
                            na_peak_reg        <= na_max_reg;
                            na_trough_reg      <= na_min_reg;
                            decay_half_reg     <= span(times_reg[3], times_reg[2]);
                            decay_ninety_reg   <= span(times_reg[5], times_reg[4]);
                            decay_tau_reg      <= span(times_reg[7], times_reg[6]);
                            time_to_peak_reg   <= span(scaled_high, scaled_low);
                        end
                        if (beat_count_reg != BEAT_MAX) begin
                            beat_count_reg <= beat_count_reg + BEAT_W'(1);
                        end
                        lidx_reg  <= '0;
                        state_reg <= ST_LMUL;
                    end
                end

                ST_LMUL: begin
                    prod_reg  <= PW'(lv_diff) * PW'(lv_coef) + ROUND_C;
                    state_reg <= ST_LADD;
                end

                ST_LADD: begin
                    nv_reg[lidx_reg] <= lv_sat;
                    lidx_reg         <= lidx_reg + 2'd1;
                    state_reg        <= (lidx_reg == 2'd3) ? ST_FIN : ST_LMUL;
                end

                ST_FIN: begin
                    prev_v_reg  <= v_reg;
                    prev_ca_reg <= ca_reg;
                    clk_cnt_reg <= clk_cnt_reg + TIME_W'(1);
                    if (eob_reg) begin
                        // New levels go to the bank of this parity; the other bank goes live.
                        for (int i = 0; i < 4; i++) begin
                            bank_reg[beat_count_reg[0]][i] <= nv_reg[i];
                            act_reg[i] <= bank_reg[!beat_count_reg[0]][i];
                        end
                        ca_high_reg <= '0;
                        ca_low_reg  <= LARGE_V;
                        sr_max_reg  <= '0;
                        sr_min_reg  <= LARGE_V;
                        na_max_reg  <= '0;
                        na_min_reg  <= LARGE_V;
                        for (int i = 0; i < 6; i++) begin
                            times_reg[i] <= '0;
                        end
                    end
                    state_reg <= ST_IDLE;
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign sample_stall   = state_reg != ST_IDLE;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == ADDR_WARMUP[2]) ? {16'b0, warmup_reg} : 32'b0;

    assign result_valid   = result_valid_reg;
    assign beat_number    = beat_number_reg;
    assign apd            = apd_reg;
    assign ca_peak        = ca_peak_reg;
    assign ca_at_boundary = ca_at_boundary_reg;
    assign sr_peak        = sr_peak_reg;
    assign sr_trough      = sr_trough_reg;
    assign na_peak        = na_peak_reg;
    assign na_trough      = na_trough_reg;
    assign decay_half     = decay_half_reg;
    assign decay_tau      = decay_tau_reg;
    assign decay_ninety   = decay_ninety_reg;
    assign time_to_peak   = time_to_peak_reg;

`ifndef NO_ASSERTIONS
    a_result_from_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_BOUND))
        else $error("result loaded outside the boundary step");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVWAIT)
        else $error("divider finished while no crossing was waiting");

    a_beat_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> beat_count_reg >= $past(beat_count_reg))
        else $error("beat count went backward");

    a_count_steps_once: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_count_reg != $past(beat_count_reg)) |-> $past(state_reg == ST_BOUND))
        else $error("beat count changed outside a boundary");
`endif

endmodule

// File: src/bwbe_div.sv
module bwbe_div #(
    parameter int OP_W = 33,
    parameter int FRAC = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] num,
    input  logic [OP_W-1:0] den,
    output logic            done,
    output logic [FRAC:0]   quot
);

    localparam int QW = FRAC + 1;
    localparam int CW = $clog2(FRAC + 2);
    localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC;

    typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

    dv_state_t       state_reg;
    logic [OP_W-1:0] rem_reg;
    logic [OP_W-1:0] den_reg;
    logic [CW-1:0]   cnt_reg;
    logic [QW-1:0]   quot_reg;
    logic            done_reg;

    logic [OP_W:0] rem_dbl;
    logic [OP_W:0] rem_sub;
    logic          fits;

    // One quotient bit per cycle by restoring division. The remainder always stays
    // below the divisor, so the doubled remainder needs just one extra bit.
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, den_reg};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= DV_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            cnt_reg   <= '0;
            quot_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        if (num >= den) begin
                            // The ratio is at least one, which is the clamp value.
                            quot_reg <= Q_ONE;
                            done_reg <= 1'b1;
                        end
                        else if (FRAC == 0) begin
                            quot_reg <= '0;
                            done_reg <= 1'b1;
                        end
                        else begin
                            rem_reg   <= num;
                            den_reg   <= den;
                            quot_reg  <= '0;
                            cnt_reg   <= CW'(FRAC);
                            state_reg <= DV_RUN;
                        end
                    end
                end
                DV_RUN: begin
                    rem_reg  <= fits ? rem_sub[OP_W-1:0] : rem_dbl[OP_W-1:0];
                    quot_reg <= (quot_reg << 1) | QW'(fits);
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
